// ----- design/hdu_pkg.sv -----
// hdu_pkg: types, codes and reset constants shared by the half-duplex UART engine.
// No dependencies; compiled first.
`default_nettype none

package hdu_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_RX   = 2'd1,
    MODE_TX   = 2'd2
  } mode_e;

  // Register word indexes on the APB port (byte address / 4)
  typedef enum logic [1:0] {
    REG_BIT_PERIOD   = 2'd0,
    REG_FIRST_DELAY  = 2'd1,
    REG_TX_TRIM      = 2'd2
  } reg_idx_e;

  localparam int unsigned PeriodW  = 16;
  localparam int unsigned TrimW    = 8;
  localparam int unsigned ShiftW   = 11;
  localparam int unsigned BitsW    = 4;
  localparam int unsigned PaddrW   = 4;

  localparam logic [PeriodW-1:0] BitPeriodRst  = 16'd104;
  localparam logic [PeriodW-1:0] FirstDelayRst = 16'd104;
  localparam logic [TrimW-1:0]   TxTrimRst     = 8'd12;

  localparam logic [BitsW-1:0]  TxBits       = 4'd10;
  localparam logic [BitsW-1:0]  RxSamples    = 4'd9;
  localparam logic [BitsW-1:0]  TrimBelow    = 4'd6;
  localparam logic [ShiftW-1:0] FrameMask    = 11'h201;
  localparam logic [ShiftW-1:0] FrameGood    = 11'h200;

  typedef struct packed {
    mode_e               mode;
    logic [BitsW-1:0]    bits_left;
    logic [PeriodW-1:0]  countdown;
    logic [ShiftW-1:0]   shift_word;
    logic                line_out;
    logic                rx_prev;
    logic [7:0]          held_byte;
  } state_t;

  typedef struct packed {
    logic [PeriodW-1:0] bit_period;
    logic [PeriodW-1:0] first_sample_delay;
    logic [TrimW-1:0]   tx_trim;
  } cfg_t;

  typedef struct packed {
    logic       rx_level;
    logic       send_valid;
    logic [7:0] send_byte;
  } item_t;

  typedef struct packed {
    logic       tx_level;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       tx_busy;
    logic       rx_busy;
    logic       send_taken;
  } result_t;

endpackage

`default_nettype wire

// ----- design/hdu_item_if.sv -----
// hdu_item_if / hdu_result_if: valid/ready channels for tick words and result words.
// No dependencies.
`default_nettype none

interface hdu_item_if;
  logic       valid;
  logic       ready;
  logic       rx_level;
  logic       send_valid;
  logic [7:0] send_byte;

  modport source (output valid, rx_level, send_valid, send_byte, input ready);
  modport sink   (input valid, rx_level, send_valid, send_byte, output ready);
endinterface

interface hdu_result_if;
  logic       valid;
  logic       ready;
  logic       tx_level;
  logic       rx_valid;
  logic [7:0] rx_data;
  logic       tx_busy;
  logic       rx_busy;
  logic       send_taken;

  modport source (output valid, tx_level, rx_valid, rx_data, tx_busy, rx_busy, send_taken,
                  input ready);
  modport sink   (input valid, tx_level, rx_valid, rx_data, tx_busy, rx_busy, send_taken,
                  output ready);
endinterface

`default_nettype wire

// ----- design/hdu_step.sv -----
// hdu_step: next-state and result logic for one tick of the UART engine.
// Depends on hdu_pkg. Purely combinational.
`default_nettype none

module hdu_step (
  input  hdu_pkg::state_t  state_i,
  input  hdu_pkg::cfg_t    cfg_i,
  input  hdu_pkg::item_t   item_i,
  output hdu_pkg::state_t  state_o,
  output hdu_pkg::result_t result_o
);
  import hdu_pkg::*;

  logic [PeriodW-1:0] trim_period;
  logic [PeriodW-1:0] tx_period;
  logic               rx_valid;
  logic               taken;
  state_t             nxt;

  always_comb begin
    if ({8'd0, cfg_i.tx_trim} >= cfg_i.bit_period) begin
      trim_period = PeriodW'(1);
    end else begin
      trim_period = cfg_i.bit_period - {8'd0, cfg_i.tx_trim};
    end
    tx_period = (state_i.bits_left < TrimBelow) ? trim_period : cfg_i.bit_period;
  end

  always_comb begin
    nxt      = state_i;
    rx_valid = 1'b0;
    taken    = 1'b0;
    case (state_i.mode) inside
      MODE_TX, MODE_RX: begin
        if (state_i.countdown > PeriodW'(1)) begin
          nxt.countdown = state_i.countdown - PeriodW'(1);
        end else if (state_i.mode == MODE_TX) begin
          if (state_i.bits_left == '0) begin
            nxt.mode     = MODE_IDLE;
            nxt.line_out = 1'b1;
          end else begin
            nxt.line_out   = state_i.shift_word[0];
            nxt.shift_word = {1'b0, state_i.shift_word[ShiftW-1:1]};
            nxt.bits_left  = state_i.bits_left - BitsW'(1);
            nxt.countdown  = tx_period;
          end
        end else begin
          if (state_i.bits_left == '0) begin
            nxt.mode = MODE_IDLE;
            if ((state_i.shift_word & FrameMask) == FrameGood) begin
              nxt.held_byte = state_i.shift_word[8:1];
              rx_valid      = 1'b1;
            end
          end else begin
            // new sample enters at bit 9 while the older samples shift down
            nxt.shift_word = {1'b0, item_i.rx_level, state_i.shift_word[ShiftW-2:1]};
            nxt.bits_left  = state_i.bits_left - BitsW'(1);
            nxt.countdown  = cfg_i.bit_period;
          end
        end
      end
      default: begin
        nxt.mode = MODE_IDLE;
        if (item_i.send_valid) begin
          taken          = 1'b1;
          nxt.mode       = MODE_TX;
          nxt.shift_word = {2'b01, item_i.send_byte, 1'b0};
          nxt.bits_left  = TxBits;
          nxt.countdown  = cfg_i.bit_period;
        end else if (state_i.rx_prev && !item_i.rx_level) begin
          nxt.mode       = MODE_RX;
          nxt.shift_word = '0;
          nxt.bits_left  = RxSamples;
          nxt.countdown  = cfg_i.first_sample_delay;
        end
      end
    endcase
    nxt.rx_prev = item_i.rx_level;
  end

  assign state_o             = nxt;
  assign result_o.tx_level   = nxt.line_out;
  assign result_o.rx_valid   = rx_valid;
  assign result_o.rx_data    = nxt.held_byte;
  assign result_o.tx_busy    = (nxt.mode == MODE_TX);
  assign result_o.rx_busy    = (nxt.mode == MODE_RX);
  assign result_o.send_taken = taken;

endmodule

`default_nettype wire

// ----- design/half_duplex_uart_engine_core.sv -----
// half_duplex_uart_engine_core: tick-stepped 8N1 half-duplex UART with APB register port.
// Depends on hdu_pkg, hdu_item_if, hdu_result_if and hdu_step.
//
//   channel   | dir | handshake            | word
//   ----------+-----+----------------------+-------------------------------------------
//   item_i    | in  | valid/ready          | rx_level, send_valid, send_byte
//   result_o  | out | valid/ready          | tx_level, rx_valid, rx_data, tx_busy,
//             |     |                      | rx_busy, send_taken
//   apb       | in  | psel/penable, pready | 4-bit paddr, 32-bit pwdata/prdata
//
// One word per cycle sustained while result_o is ready. A word waits in the input register,
// where the step logic updates the engine state and loads the result register.
// The input register refills in the cycle the result register is drained, so a stalled
// result side holds at most one word in each register. Reset is asynchronous, active low,
// and sets engine state, config and valid flags to their defaults; no clearing pass is needed.
`default_nettype none

module half_duplex_uart_engine_core (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  hdu_item_if.sink                     item_i,
  hdu_result_if.source                 result_o,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [hdu_pkg::PaddrW-1:0]   paddr,
  input  wire  [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import hdu_pkg::*;

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  item_t   in_q;
  logic    in_valid_q;
  result_t out_q, out_d;
  logic    out_valid_q;
  logic    advance;
  logic    cfg_we;
  reg_idx_e reg_idx;

  assign reg_idx = reg_idx_e'(paddr[PaddrW-1:2]);
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      REG_BIT_PERIOD:  prdata = {16'd0, cfg_q.bit_period};
      REG_FIRST_DELAY: prdata = {16'd0, cfg_q.first_sample_delay};
      REG_TX_TRIM:     prdata = {24'd0, cfg_q.tx_trim};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_period         <= BitPeriodRst;
      cfg_q.first_sample_delay <= FirstDelayRst;
      cfg_q.tx_trim            <= TxTrimRst;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_BIT_PERIOD:  cfg_q.bit_period         <= pwdata[15:0];
        REG_FIRST_DELAY: cfg_q.first_sample_delay <= pwdata[15:0];
        REG_TX_TRIM:     cfg_q.tx_trim            <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // a word in the input register steps the engine once the result slot is free or being drained
  assign advance      = in_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      in_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      in_q.rx_level   <= item_i.rx_level;
      in_q.send_valid <= item_i.send_valid;
      in_q.send_byte  <= item_i.send_byte;
    end
  end

  hdu_step u_step (
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .item_i   (in_q),
    .state_o  (state_d),
    .result_o (out_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode       <= MODE_IDLE;
      state_q.bits_left  <= '0;
      state_q.countdown  <= '0;
      state_q.shift_word <= '0;
      state_q.line_out   <= 1'b1;
      state_q.rx_prev    <= 1'b1;
      state_q.held_byte  <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.tx_level   = out_q.tx_level;
  assign result_o.rx_valid   = out_q.rx_valid;
  assign result_o.rx_data    = out_q.rx_data;
  assign result_o.tx_busy    = out_q.tx_busy;
  assign result_o.rx_busy    = out_q.rx_busy;
  assign result_o.send_taken = out_q.send_taken;

  a_taken_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.send_taken |-> out_q.tx_busy && !out_q.rx_busy)
    else $error("send accepted without entering transmit");

  a_rx_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.rx_valid |-> !out_q.rx_busy && !out_q.tx_busy)
    else $error("frame judged while engine still busy");

  a_bits_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.bits_left <= TxBits)
    else $error("bit counter out of range");

  a_step_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("stepped word lost before result register");

  a_idle_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.mode == MODE_RX |-> state_q.line_out)
    else $error("tx line low while receiving");

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// tb_top: self-checking testbench for half_duplex_uart_engine_core (tick-stepped 8N1 UART).
// Depends on hdu_pkg and the hdu_item_if / hdu_result_if interfaces; drives the APB
// register port and checks every result word against a built-in engine predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hdu_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PaddrW-1:0]  paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  hdu_item_if   item_bus ();
  hdu_result_if result_bus ();

  half_duplex_uart_engine_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_bus),
    .result_o (result_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- engine predictor
  state_t eng;
  cfg_t   regs;

  function automatic result_t uart_tick(item_t w);
    result_t            r;
    logic [PeriodW-1:0] period;
    r = '0;
    if (eng.mode == MODE_TX || eng.mode == MODE_RX) begin
      if (eng.countdown > 1) begin
        eng.countdown = eng.countdown - 1'b1;
      end else if (eng.mode == MODE_TX) begin
        if (eng.bits_left == '0) begin
          eng.mode = MODE_IDLE;
          eng.line_out = 1'b1;
        end else begin
          period = regs.bit_period;
          // late bits run short; a trim at or above the period leaves one tick
          if (eng.bits_left < TrimBelow)
            period = (regs.tx_trim >= regs.bit_period) ? PeriodW'(1)
                                                        : regs.bit_period - regs.tx_trim;
          eng.line_out = eng.shift_word[0];
          eng.shift_word = eng.shift_word >> 1;
          eng.bits_left = eng.bits_left - 1'b1;
          eng.countdown = period;
        end
      end else if (eng.bits_left == '0) begin
        eng.mode = MODE_IDLE;
        if ((eng.shift_word & FrameMask) == FrameGood) begin
          eng.held_byte = eng.shift_word[8:1];
          r.rx_valid = 1'b1;
        end
      end else begin
        eng.shift_word = {1'b0, eng.shift_word[10] | w.rx_level, eng.shift_word[9:1]};
        eng.bits_left = eng.bits_left - 1'b1;
        eng.countdown = regs.bit_period;
      end
    end else begin
      eng.mode = MODE_IDLE;
      if (w.send_valid) begin
        r.send_taken = 1'b1;
        eng.mode = MODE_TX;
        eng.shift_word = {2'b01, w.send_byte, 1'b0};
        eng.bits_left = TxBits;
        eng.countdown = regs.bit_period;
      end else if (eng.rx_prev && !w.rx_level) begin
        eng.mode = MODE_RX;
        eng.shift_word = '0;
        eng.bits_left = RxSamples;
        eng.countdown = regs.first_sample_delay;
      end
    end
    eng.rx_prev = w.rx_level;
    r.tx_level = eng.line_out;
    r.rx_data = eng.held_byte;
    r.tx_busy = (eng.mode == MODE_TX);
    r.rx_busy = (eng.mode == MODE_RX);
    return r;
  endfunction

  // ---------------------------------------------------------------- tick driver
  item_t   pending_words[$];
  result_t expected_words[$];
  item_t   word_out;
  logic    offering;
  int      send_gap_left;
  int      send_gap_max;
  int      queued_ticks;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offering = 1'b0;
      send_gap_left = 0;
      item_bus.valid <= 1'b0;
    end else begin
      if (item_bus.valid && item_bus.ready) begin
        expected_words.push_back(uart_tick(item_t'({item_bus.rx_level, item_bus.send_valid,
                                                    item_bus.send_byte})));
        offering = 1'b0;
        send_gap_left = $urandom_range(0, send_gap_max);
      end
      if (!offering) begin
        if (send_gap_left > 0) begin
          send_gap_left--;
        end else if (pending_words.size() != 0) begin
          word_out = pending_words.pop_front();
          offering = 1'b1;
        end
      end
      item_bus.valid      <= offering;
      item_bus.rx_level   <= word_out.rx_level;
      item_bus.send_valid <= word_out.send_valid;
      item_bus.send_byte  <= word_out.send_byte;
    end
  end

  // ---------------------------------------------------------------- result monitor
  result_t got_word;
  result_t want_word;
  int      recv_stall_left;
  int      recv_stall_max;
  logic    hold_request;
  int      mismatches;
  int      words_checked;
  int      frames_seen;
  int      sends_seen;

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      if (mismatches < 200) $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recv_stall_left = 0;
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        got_word = result_t'({result_bus.tx_level, result_bus.rx_valid, result_bus.rx_data,
                              result_bus.tx_busy, result_bus.rx_busy, result_bus.send_taken});
        if (expected_words.size() == 0) begin
          if (mismatches < 200) $error("result word arrived with nothing expected");
          mismatches++;
        end else begin
          want_word = expected_words.pop_front();
          words_checked++;
          frames_seen += int'(want_word.rx_valid);
          sends_seen += int'(want_word.send_taken);
          compare_field("tx_level", 8'(want_word.tx_level), 8'(got_word.tx_level));
          compare_field("rx_valid", 8'(want_word.rx_valid), 8'(got_word.rx_valid));
          compare_field("rx_data", want_word.rx_data, got_word.rx_data);
          compare_field("tx_busy", 8'(want_word.tx_busy), 8'(got_word.tx_busy));
          compare_field("rx_busy", 8'(want_word.rx_busy), 8'(got_word.rx_busy));
          compare_field("send_taken", 8'(want_word.send_taken), 8'(got_word.send_taken));
        end
        recv_stall_left = $urandom_range(0, recv_stall_max);
      end
      // long back-pressure: both internal registers fill and item ready drops
      if (hold_request) begin
        recv_stall_left = 300;
        hold_request = 1'b0;
      end
      if (recv_stall_left > 0) begin
        recv_stall_left--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic void queue_tick(logic rx, logic send, logic [7:0] b);
    pending_words.push_back(item_t'({rx, send, b}));
    queued_ticks++;
  endfunction

  // serial frame on rx, one level per bit period; samples land where the
  // programmed first delay puts them
  function automatic void queue_rx_frame(int p, int d, logic [7:0] data, logic stop_bit);
    int   k;
    logic lvl;
    for (int i = 0; i <= d + 9 * p; i++) begin
      k = i / p;
      if (k == 0) lvl = 1'b0;
      else if (k <= 8) lvl = data[k - 1];
      else lvl = stop_bit;
      queue_tick(lvl, i > 0 && $urandom_range(0, 7) == 0, 8'($urandom));
    end
    // a line held low after the frame must not start another reception
    queue_tick(stop_bit, 1'b0, 8'($urandom));
    repeat ($urandom_range(1, 3)) queue_tick(1'b1, 1'b0, 8'($urandom));
  endfunction

  function automatic void queue_send(int p, logic [7:0] data);
    queue_tick(1'($urandom_range(0, 1)), 1'b1, data);
    for (int i = 1; i <= 11 * p; i++) begin
      if (i <= 5 * p)
        queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 3) == 0), 8'($urandom));
      else
        queue_tick(1'b1, 1'b0, 8'($urandom));
    end
  endfunction

  function automatic void queue_noise(int p, int d);
    int n;
    int settle;
    n = $urandom_range(1, 20);
    settle = ((11 * p > d + 9 * p) ? 11 * p : d + 9 * p) + 2;
    for (int i = 0; i < n; i++)
      queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 2) == 0), 8'($urandom));
    for (int i = 0; i < settle; i++) queue_tick(1'b1, 1'b0, 8'($urandom));
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_BIT_PERIOD:  regs.bit_period = value[PeriodW-1:0];
      REG_FIRST_DELAY: regs.first_sample_delay = value[PeriodW-1:0];
      REG_TX_TRIM:     regs.tx_trim = value[TrimW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(int period, int delay, int trim);
    write_reg(REG_BIT_PERIOD, 32'(period));
    write_reg(REG_FIRST_DELAY, 32'(delay));
    write_reg(REG_TX_TRIM, 32'(trim));
  endtask

  // every word is in, every result is back, and the engine has had time to settle
  task automatic drain();
    while (pending_words.size() != 0 || offering || expected_words.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int period;
    int delay;
    int trim;
    int p;
    int d;
    int start;
    item_bus.valid = 1'b0;
    item_bus.rx_level = 1'b1;
    item_bus.send_valid = 1'b0;
    item_bus.send_byte = '0;
    result_bus.ready = 1'b0;
    word_out = item_t'({1'b1, 1'b0, 8'h00});
    eng = '{mode: MODE_IDLE, bits_left: '0, countdown: '0, shift_word: '0,
            line_out: 1'b1, rx_prev: 1'b1, held_byte: '0};
    regs = '{bit_period: BitPeriodRst, first_sample_delay: FirstDelayRst,
             tx_trim: TxTrimRst};
    send_gap_max = 0;
    recv_stall_max = 0;
    hold_request = 1'b0;
    mismatches = 0;
    queued_ticks = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero period and zero first delay act as one tick, trim beyond period
    set_regs(0, 0, 255);
    queue_tick(1'b1, 1'b0, 8'h00);
    queue_tick(1'b0, 1'b1, 8'hff);                 // send and rx edge together: send wins
    for (int i = 0; i < 11; i++)                   // busy: sends and edges ignored
      queue_tick((i == 10) ? 1'b1 : 1'(i % 2), 1'b1, 8'h00);
    queue_tick(1'b0, 1'b0, 8'h00);                 // falling edge, reception starts
    for (int i = 0; i < 10; i++) queue_tick(1'b1, 1'b1, 8'h00);  // 0xff, stop, verdict
    drain();

    // widest register values; no frame is started at this rate
    set_regs(65535, 65535, 0);
    repeat (16) queue_tick(1'b1, 1'b0, 8'($urandom));
    drain();

    for (int ph = 0; ph < 14; ph++) begin
      case (ph)
        0: begin period = 1; delay = 1; trim = 0; end
        1: begin period = 3; delay = 5; trim = 255; end
        2: begin period = 8; delay = 12; trim = 3; end
        default: begin
          period = $urandom_range(0, 4);
          p = (period == 0) ? 1 : period;
          delay = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3 * p) : p + p / 2;
          trim = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, p);
        end
      endcase
      p = (period == 0) ? 1 : period;
      d = (delay == 0) ? 1 : delay;
      set_regs(period, delay, trim);
      send_gap_max = (ph % 3 == 1) ? 0 : 16;
      recv_stall_max = (ph % 4 == 2) ? 0 : 16;
      if (ph == 4) begin
        send_gap_max = 0;
        hold_request = 1'b1;
      end
      start = queued_ticks;
      while (queued_ticks - start < 85) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: queue_rx_frame(p, d, 8'($urandom), 1'($urandom_range(0, 4) != 0));
          4, 5, 6, 7: queue_send(p, 8'($urandom));
          default:    queue_noise(p, d);
        endcase
      end
      drain();
    end

    $display("Checked %0d result words over 16 register settings;", words_checked);
    $display("%0d good frames received and %0d bytes accepted for sending.",
             frames_seen, sends_seen);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
